// ----- rtl/mwtg_pkg.sv -----
// shared types, register codes and the sine table builder for the tone generator
`default_nettype none

package mwtg_pkg;

    // waveform select codes
    typedef enum logic [1:0] {
        WAVE_SINE     = 2'd0,
        WAVE_SAWTOOTH = 2'd1,
        WAVE_SQUARE   = 2'd2,
        WAVE_TRIANGLE = 2'd3
    } wave_t;

    // register indexes on the apb port
    typedef logic [1:0] reg_idx_t;
    localparam reg_idx_t REG_WAVEFORM   = 2'd0;
    localparam reg_idx_t REG_PHASE_STEP = 2'd1;
    localparam reg_idx_t REG_AMPLITUDE  = 2'd2;

    localparam int unsigned PADDR_BITS = 4;
    localparam logic [14:0] FULL_SCALE = 15'd32767;
    localparam logic [15:0] AMP_RESET  = 16'd32768;
    localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

    // x^2 step of the taylor series in q30
    function automatic logic [63:0] sq_step(input logic [63:0] term, input logic [63:0] x);
        logic [63:0] t;
        t = (term * x) >> 30;
        t = (t * x) >> 30;
        return t;
    endfunction

    // quarter-wave sine entry, 32767 * sin(pi/2 * k / 2^addr_bits), elaboration only
    function automatic logic [14:0] sine_entry(input logic [31:0] k,
                                               input int unsigned addr_bits);
        logic [63:0]        x;
        logic [63:0]        term;
        logic [63:0]        v;
        logic signed [63:0] sum;
        x    = (HALF_PI_Q30 * {32'd0, k}) >> addr_bits;
        term = x;
        sum  = $signed(x);
        term = sq_step(term, x) / 64'd6;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd20;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd42;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd72;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd110;
        sum  = sum - $signed(term);
        term = sq_step(term, x) / 64'd156;
        sum  = sum + $signed(term);
        term = sq_step(term, x) / 64'd210;
        sum  = sum - $signed(term);
        if (sum < 0)
        begin
            sum = 64'sd0;
        end
        v = (($unsigned(sum) * 64'd32767) + (64'd1 << 29)) >> 30;
        if (v > 64'd32767)
        begin
            v = 64'd32767;
        end
        return v[14:0];
    endfunction

endpackage

`default_nettype wire

// ----- rtl/multi_waveform_tone_generator_top.sv -----
// top level of the multi-waveform phase-accumulator tone generator
`default_nettype none

// Phase-accumulator tone generator. Every word accepted on the input channel yields
// exactly one signed 16-bit sample on the output channel; restart=1 clears the phase
// before that sample is formed, and the phase then advances by phase_step (modulo
// 2^PHASE_BITS). Waveform 0 is sine from a quarter-wave table, 1 sawtooth, 2 bipolar
// square, 3 triangle; the result is scaled by a Q1.15 amplitude and saturated to
// +-32767. One word is taken every clock while in_ready is high; each sample passes
// through the registered sine table read, the waveform magnitude stage and the gain
// multiplier stage. Each stage holds while the one after it is full, so a stalled
// output does not block the input until all three stages fill.
// Registers (APB, 32-bit, byte addresses): 0x0 waveform, 0x4 phase_step,
// 0x8 amplitude (reset 32768 = 1.0); write them only while no word is in flight.
module multi_waveform_tone_generator_top #(
    parameter int unsigned PHASE_BITS     = 32,
    parameter int unsigned SINE_ADDR_BITS = 10
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // apb configuration port
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [mwtg_pkg::PADDR_BITS-1:0]   paddr,
    input  wire logic [31:0]                       pwdata,
    output logic      [31:0]                       prdata,
    output logic                                   pready,
    // input word
    input  wire logic                              in_valid,
    output logic                                   in_ready,
    input  wire logic                              restart,
    // output word
    output logic                                   out_valid,
    input  wire logic                              out_ready,
    output logic signed [15:0]                     sample
);

    localparam int unsigned PB = PHASE_BITS;
    localparam int unsigned AB = SINE_ADDR_BITS;
    localparam int unsigned QUARTER_LEN = 1 << AB;
    // one full turn of phase, and the same at two extra bits for the triangle
    localparam logic [PB:0]   ONE_TURN   = {1'b1, {PB{1'b0}}};
    localparam logic [PB+1:0] ONE_TURN_W = {2'b01, {PB{1'b0}}};
    localparam logic [AB:0]   QUARTER    = {1'b1, {AB{1'b0}}};

    // ---------------------------------------------------------------
    // configuration registers
    // ---------------------------------------------------------------
    mwtg_pkg::wave_t   waveform_reg;
    logic [31:0]       phase_step_reg;
    logic [15:0]       amplitude_reg;
    logic              cfg_write;
    mwtg_pkg::reg_idx_t cfg_idx;

    assign cfg_write = psel && penable && pwrite;
    assign cfg_idx   = paddr[3:2];
    assign pready    = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            waveform_reg   <= mwtg_pkg::WAVE_SINE;
            phase_step_reg <= 32'd0;
            amplitude_reg  <= mwtg_pkg::AMP_RESET;
        end
        else if (cfg_write)
        begin
            unique case (cfg_idx)
                mwtg_pkg::REG_WAVEFORM:   waveform_reg   <= mwtg_pkg::wave_t'(pwdata[1:0]);
                mwtg_pkg::REG_PHASE_STEP: phase_step_reg <= pwdata;
                mwtg_pkg::REG_AMPLITUDE:  amplitude_reg  <= pwdata[15:0];
                default:                  ;  // unmapped address, write dropped
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            mwtg_pkg::REG_WAVEFORM:   prdata = {30'd0, waveform_reg};
            mwtg_pkg::REG_PHASE_STEP: prdata = phase_step_reg;
            mwtg_pkg::REG_AMPLITUDE:  prdata = {16'd0, amplitude_reg};
            default:                  prdata = 32'd0;
        endcase
    end

    // ---------------------------------------------------------------
    // pipeline flow control: each stage moves when the one after it has room
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic out_valid_reg;
    logic adv1;
    logic adv2;
    logic adv3;
    logic in_accept;

    assign adv3      = !out_valid_reg || out_ready;
    assign adv2      = !s2_valid_reg || adv3;
    assign adv1      = !s1_valid_reg || adv2;
    assign in_ready  = adv1;
    assign in_accept = in_valid && adv1;
    assign out_valid = out_valid_reg;

    // ---------------------------------------------------------------
    // phase accumulator
    // ---------------------------------------------------------------
    logic [PB-1:0]   phase_reg;
    logic [PB-1:0]   phase_next;
    logic [PB-1:0]   phase_cur;
    logic [PB-1:0]   step_eff;
    logic [PB+31:0]  step_wide;

    // only the low PHASE_BITS of the step take part; narrower steps are zero extended
    assign step_wide  = {{PB{1'b0}}, phase_step_reg};
    assign step_eff   = step_wide[PB-1:0];
    assign phase_cur  = restart ? '0 : phase_reg;
    assign phase_next = phase_cur + step_eff;

    // ---------------------------------------------------------------
    // stage 1 inputs: sine table address, fraction magnitude and sign
    // ---------------------------------------------------------------
    logic [1:0]      quad;
    logic [AB-1:0]   sine_idx;
    logic [AB:0]     sine_addr;
    logic [PB:0]     dmag;
    logic [PB+1:0]   dmag2;
    logic            tri_neg;
    logic [PB+1:0]   tri_mag;
    logic [PB:0]     frac_mag_next;
    logic            neg1_next;

    assign quad      = phase_cur[PB-1 -: 2];
    assign sine_idx  = phase_cur[PB-3 -: AB];
    // odd quadrants read the table backwards
    assign sine_addr = quad[0] ? (QUARTER - {1'b0, sine_idx}) : {1'b0, sine_idx};

    // distance from mid-cycle, doubled: 2|p - 0.5| in phase units
    assign dmag    = phase_cur[PB-1] ? {1'b0, phase_cur[PB-2:0], 1'b0}
                                     : ONE_TURN - {1'b0, phase_cur[PB-2:0], 1'b0};
    assign dmag2   = {dmag, 1'b0};
    assign tri_neg = dmag2 > ONE_TURN_W;
    assign tri_mag = tri_neg ? (dmag2 - ONE_TURN_W) : (ONE_TURN_W - dmag2);

    always_comb
    begin
        unique case (waveform_reg)
            mwtg_pkg::WAVE_SAWTOOTH:
            begin
                neg1_next     = !phase_cur[PB-1];
                frac_mag_next = dmag;
            end
            mwtg_pkg::WAVE_TRIANGLE:
            begin
                neg1_next     = tri_neg;
                frac_mag_next = tri_mag[PB:0];
            end
            default:
            begin
                // sine and square take the sign from the phase msb
                neg1_next     = phase_cur[PB-1];
                frac_mag_next = dmag;
            end
        endcase
    end

    // ---------------------------------------------------------------
    // quarter-wave sine rom, built at elaboration
    // ---------------------------------------------------------------
    logic [14:0] sine_rom [QUARTER_LEN+1];

    for (genvar k = 0; k <= QUARTER_LEN; k++)
    begin : g_sine_rom
        localparam logic [14:0] ENTRY = mwtg_pkg::sine_entry(32'(k), AB);
        assign sine_rom[k] = ENTRY;
    end

    // ---------------------------------------------------------------
    // stage 1 registers
    // ---------------------------------------------------------------
    logic [14:0] sine_data_reg;
    logic [PB:0] frac_mag_reg;
    logic        neg1_reg;

    always_ff @(posedge clk)
    begin
        if (adv1)
        begin
            sine_data_reg <= sine_rom[sine_addr];
            frac_mag_reg  <= frac_mag_next;
            neg1_reg      <= neg1_next;
        end
    end

    // ---------------------------------------------------------------
    // stage 2: waveform magnitude |w| in [0, 32767]
    // ---------------------------------------------------------------
    logic [PB+15:0] frac_scaled;
    logic [14:0]    wmag_next;
    logic [14:0]    wmag_reg;
    logic           neg2_reg;

    // 32767 * m as (m << 15) - m, then drop the phase fraction bits
    assign frac_scaled = {frac_mag_reg, 15'd0} - {15'd0, frac_mag_reg};

    always_comb
    begin
        unique case (waveform_reg)
            mwtg_pkg::WAVE_SINE:   wmag_next = sine_data_reg;
            mwtg_pkg::WAVE_SQUARE: wmag_next = mwtg_pkg::FULL_SCALE;
            default:               wmag_next = frac_scaled[PB+14:PB];
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (adv2)
        begin
            wmag_reg <= wmag_next;
            neg2_reg <= neg1_reg;
        end
    end

    // ---------------------------------------------------------------
    // stage 3: gain, saturation and sign
    // ---------------------------------------------------------------
    logic [30:0]        gain_prod;
    logic [15:0]        gain_mag;
    logic [14:0]        sat_mag;
    logic signed [15:0] sample_next;
    logic signed [15:0] sample_reg;

    assign gain_prod   = {15'd0, amplitude_reg} * {16'd0, wmag_reg};
    assign gain_mag    = gain_prod[30:15];
    assign sat_mag     = gain_mag[15] ? mwtg_pkg::FULL_SCALE : gain_mag[14:0];
    assign sample_next = neg2_reg ? -$signed({1'b0, sat_mag}) : $signed({1'b0, sat_mag});

    always_ff @(posedge clk)
    begin
        if (adv3)
        begin
            sample_reg <= sample_next;
        end
    end

    assign sample = sample_reg;

    // ---------------------------------------------------------------
    // control state
    // ---------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= '0;
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_accept)
            begin
                phase_reg <= phase_next;
            end
            if (adv1)
            begin
                s1_valid_reg <= in_valid;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (adv3)
            begin
                out_valid_reg <= s2_valid_reg;
            end
        end
    end

`ifndef SYNTHESIS
    // a restarted word leaves exactly one step of phase behind it
    assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && restart |=> phase_reg == $past(step_eff))
        else $error("phase after restart is not one step");

    // input only stalls when every stage is full and the output is held
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid_reg && s2_valid_reg && s1_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

    // saturation keeps samples symmetric
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> sample_reg != 16'sh8000)
        else $error("sample reached -32768");
`endif

endmodule

`default_nettype wire
